// File: sv/bmm_pkg.sv
package bmm_pkg;

   localparam int DEF_MAX_N     = 32;
   localparam int DEF_MAX_BLOCK = 8;

   localparam int CMD_W   = 2;
   localparam int COORD_W = 5;
   localparam int ELEM_W  = 16;
   localparam int OUT_W   = 37;
   localparam int MS_W    = 6;
   localparam int BS_W    = 4;
   localparam int CSR_W   = 6;
   localparam int CSR_IDX_W = 1;

   localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE  = 1'b1;

   localparam logic [MS_W-1:0] MATRIX_SIZE_RESET = 6'd32;
   localparam logic [BS_W-1:0] BLOCK_SIZE_RESET  = 4'd8;

   localparam logic signed [63:0] OUT_MAX = 64'sd68719476735;
   localparam logic signed [63:0] OUT_MIN = -64'sd68719476736;

   typedef struct packed {
      logic wr_a;
      logic wr_b;
      logic issue;
      logic first;
      logic last_k;
      logic load;
      logic load_last;
   } bmm_cmd_type;

   typedef struct packed {
      logic sum_done;
      logic out_free;
   } bmm_status_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } bmm_stage_type;

endpackage

// File: sv/bmm_ctrl.sv
module bmm_ctrl
   import bmm_pkg::*;
#(
   parameter int MAX_N     = DEF_MAX_N,
   parameter int MAX_BLOCK = DEF_MAX_BLOCK,
   localparam int NW = $clog2(MAX_N + 1),
   localparam int IW = $clog2(MAX_N),
   localparam int BW = $clog2(MAX_BLOCK + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [COORD_W-1:0]   req_row,
   input  logic [COORD_W-1:0]   req_col,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   input  bmm_status_type       status,
   output bmm_cmd_type          cmd,
   output logic [IW-1:0]        row_idx,
   output logic [IW-1:0]        col_idx,
   output logic [IW-1:0]        k_idx
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_EMIT} state_type;

   state_type       state_ff;
   logic [MS_W-1:0] matrix_size_ff;
   logic [BS_W-1:0] block_size_ff;
   logic [NW-1:0]   i_ff, j_ff, k_ff, c0_ff, rend_ff, cend_ff;

   logic [NW-1:0]   n;
   logic [BW-1:0]   b;
   logic [NW-1:0]   rend_in, cend_in;
   logic            accept, tile_ok, last_elem, write_ok;

   always_comb begin
      if (matrix_size_ff == '0) begin
         n = NW'(1);
      end else if (int'(matrix_size_ff) > MAX_N) begin
         n = NW'(MAX_N);
      end else begin
         n = NW'(matrix_size_ff);
      end
      if (block_size_ff == '0) begin
         b = BW'(1);
      end else if (int'(block_size_ff) > MAX_BLOCK) begin
         b = BW'(MAX_BLOCK);
      end else begin
         b = BW'(block_size_ff);
      end
   end

   always_comb begin
      int rsum;
      int csum;
      rsum = int'(req_row) + int'(b);
      csum = int'(req_col) + int'(b);
      rend_in = (rsum < int'(n)) ? NW'(rsum) : n;
      cend_in = (csum < int'(n)) ? NW'(csum) : n;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign tile_ok   = (int'(req_row) < int'(n)) && (int'(req_col) < int'(n));
   assign write_ok  = (int'(req_row) < MAX_N) && (int'(req_col) < MAX_N);
   assign last_elem = (i_ff == rend_ff - NW'(1)) && (j_ff == cend_ff - NW'(1));

   always_comb begin
      cmd           = '0;
      cmd.wr_a      = accept && (req_cmd == CMD_WRITE_A) && write_ok;
      cmd.wr_b      = accept && (req_cmd == CMD_WRITE_B) && write_ok;
      cmd.issue     = (state_ff == ST_RUN);
      cmd.first     = (k_ff == '0);
      cmd.last_k    = (k_ff == n - NW'(1));
      cmd.load      = (state_ff == ST_EMIT) && status.out_free;
      cmd.load_last = last_elem;
   end

   assign row_idx = i_ff[IW-1:0];
   assign col_idx = j_ff[IW-1:0];
   assign k_idx   = k_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         matrix_size_ff <= MATRIX_SIZE_RESET;
         block_size_ff  <= BLOCK_SIZE_RESET;
         i_ff    <= '0;
         j_ff    <= '0;
         k_ff    <= '0;
         c0_ff   <= '0;
         rend_ff <= '0;
         cend_ff <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_MATRIX_SIZE: matrix_size_ff <= csr_data[MS_W-1:0];
               CSR_BLOCK_SIZE:  block_size_ff  <= csr_data[BS_W-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_cmd == CMD_COMPUTE) && tile_ok) begin
                  i_ff     <= NW'(req_row);
                  j_ff     <= NW'(req_col);
                  c0_ff    <= NW'(req_col);
                  rend_ff  <= rend_in;
                  cend_ff  <= cend_in;
                  k_ff     <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               k_ff <= k_ff + NW'(1);
               if (k_ff == n - NW'(1)) begin
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (status.sum_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (status.out_free) begin
                  if (last_elem) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     k_ff <= '0;
                     if (j_ff == cend_ff - NW'(1)) begin
                        j_ff <= c0_ff;
                        i_ff <= i_ff + NW'(1);
                     end else begin
                        j_ff <= j_ff + NW'(1);
                     end
                     state_ff <= ST_RUN;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> k_ff < n)
      else $error("k index beyond matrix size");

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      status.sum_done |-> state_ff == ST_WAIT)
      else $error("sum finished outside the wait state");

   a_elem_in_tile: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> (i_ff < rend_ff) && (j_ff < cend_ff))
      else $error("emitted element outside the tile");

endmodule

// File: sv/bmm_datapath.sv
module bmm_datapath
   import bmm_pkg::*;
#(
   parameter int MAX_N = DEF_MAX_N,
   localparam int IW  = $clog2(MAX_N),
   localparam int AAW = $clog2(MAX_N * MAX_N),
   localparam int ACW = 32 + $clog2(MAX_N)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bmm_cmd_type               cmd,
   output bmm_status_type            status,
   input  logic [IW-1:0]             row_idx,
   input  logic [IW-1:0]             col_idx,
   input  logic [IW-1:0]             k_idx,
   input  logic [COORD_W-1:0]        req_row,
   input  logic [COORD_W-1:0]        req_col,
   input  logic signed [ELEM_W-1:0]  req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [COORD_W-1:0]        rsp_out_row,
   output logic [COORD_W-1:0]        rsp_out_col,
   output logic signed [OUT_W-1:0]   rsp_out_value,
   output logic                      rsp_last
);

   logic signed [ELEM_W-1:0] a_mem [MAX_N*MAX_N];
   logic signed [ELEM_W-1:0] b_mem [MAX_N*MAX_N];

   logic signed [ELEM_W-1:0] a_rd_ff, b_rd_ff;
   logic signed [31:0]       prod_ff;
   logic signed [ACW-1:0]    acc_ff, acc_in;
   bmm_stage_type            p1_ff, p2_ff;
   logic                     done_ff;
   logic                     rsp_valid_ff, rsp_last_ff;
   logic [COORD_W-1:0]       out_row_ff, out_col_ff;
   logic signed [OUT_W-1:0]  out_value_ff, out_value_in;

   logic [AAW-1:0] wr_addr, a_addr, b_addr;
   logic signed [63:0] acc_wide;

   assign wr_addr = AAW'(IW'(req_row)) * AAW'(MAX_N) + AAW'(IW'(req_col));
   assign a_addr  = AAW'(row_idx) * AAW'(MAX_N) + AAW'(k_idx);
   assign b_addr  = AAW'(k_idx) * AAW'(MAX_N) + AAW'(col_idx);

   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         a_mem[wr_addr] <= req_value;
      end
      if (cmd.wr_b) begin
         b_mem[wr_addr] <= req_value;
      end
      a_rd_ff <= a_mem[a_addr];
      b_rd_ff <= b_mem[b_addr];
   end

   assign acc_in = p2_ff.first ? ACW'(prod_ff) : acc_ff + ACW'(prod_ff);

   always_comb begin
      acc_wide = 64'(acc_ff);
      if (acc_wide > OUT_MAX) begin
         out_value_in = OUT_W'(OUT_MAX);
      end else if (acc_wide < OUT_MIN) begin
         out_value_in = OUT_W'(OUT_MIN);
      end else begin
         out_value_in = OUT_W'(acc_wide);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_rd_ff * b_rd_ff;
      if (p2_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (cmd.load) begin
         out_row_ff   <= COORD_W'(row_idx);
         out_col_ff   <= COORD_W'(col_idx);
         out_value_ff <= out_value_in;
         rsp_last_ff  <= cmd.load_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff        <= '0;
         p2_ff        <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_ff   <= '{valid: cmd.issue, first: cmd.first, last: cmd.last_k};
         p2_ff   <= p1_ff;
         done_ff <= p2_ff.valid && p2_ff.last;
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.sum_done = done_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = out_row_ff;
   assign rsp_out_col   = out_col_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_last      = rsp_last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register loaded while a beat is stalled");

endmodule

// File: sv/blocked_matrix_multiply_core.sv
// Blocked square matrix multiply C = A x B. Write beats (cmd write A / write B) load one
// 16-bit element into the A or B store; a compute beat names the top-left corner of an
// output tile, and the core returns each C element of the tile in row-major order, with
// last set on the final one. Each element is a full dot product over n terms
// (n = matrix_size) built by one multiply-accumulate per cycle, fed by a single read port
// on each store. The core takes no new beat while a tile is in progress. The stores are
// not cleared at reset; only written elements may be used.
module blocked_matrix_multiply_core
   import bmm_pkg::*;
#(
   parameter int MAX_N     = DEF_MAX_N,
   parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic [COORD_W-1:0]       req_row,
   input  logic [COORD_W-1:0]       req_col,
   input  logic signed [ELEM_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [COORD_W-1:0]       rsp_out_row,
   output logic [COORD_W-1:0]       rsp_out_col,
   output logic signed [OUT_W-1:0]  rsp_out_value,
   output logic                     rsp_last,
   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_data
);

   localparam int IW = $clog2(MAX_N);

   bmm_cmd_type    cmd;
   bmm_status_type status;
   logic [IW-1:0]  row_idx, col_idx, k_idx;

   bmm_ctrl #(
      .MAX_N     (MAX_N),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .req_row   (req_row),
      .req_col   (req_col),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .status    (status),
      .cmd       (cmd),
      .row_idx   (row_idx),
      .col_idx   (col_idx),
      .k_idx     (k_idx)
   );

   bmm_datapath #(
      .MAX_N (MAX_N)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .row_idx       (row_idx),
      .col_idx       (col_idx),
      .k_idx         (k_idx),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last)
   );

endmodule
